[design/bdeq_pkg.sv]
`default_nettype none

package bdeq_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;

    // operation codes carried in the kind field
    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_PEEK       = 3'd4
    } t_kind;

    // register word index (paddr[2])
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [CNT_W-1:0]         CAP_RESET   = 5'd16;
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

endpackage

`default_nettype wire

[design/bounded_double_ended_queue_core.sv]
`default_nettype none

// Bounded double-ended queue of signed 32-bit values.
// Input channel (i_in_valid / o_in_ready): one operation per transfer,
//   i_kind selects push front, push back, pop front, pop back or peek;
//   i_value is the word to push. Codes 5..7 are refused and change nothing.
// Output channel (o_out_valid / i_out_ready): one result per operation with
//   accept flag, count, empty/full flags and the front and rear words after
//   the operation (-1 on both when the queue is empty).
// Latency: the result is presented on the cycle after the input transfer.
// Throughput: one operation per cycle; index/count update, ring write and
//   both ring reads happen at the same edge, set by the single write port.
// Stall: the result register holds while i_out_ready is low; a new operation
//   is taken only in a cycle where the result register empties or is empty,
//   so o_in_ready follows i_out_ready when a result is pending.
// Reset (synchronous, active low): queue empty, head at 0, capacity 16,
//   no result pending. Ring contents are not cleared; an unwritten entry is
//   read only while the queue is empty, and both outputs then show -1.
// Config: APB register 0 (byte address 0) is capacity[4:0]; the limit in use
//   is min(capacity, DEPTH). Change it only while the queue is empty and idle.
module bounded_double_ended_queue_core #(
    parameter int DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [2:0]                         i_kind,
    input  wire logic signed [bdeq_pkg::DATA_W-1:0] i_value,
    // output channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_accepted,
    output logic      [bdeq_pkg::CNT_W-1:0]         o_count,
    output logic                                    o_is_empty,
    output logic                                    o_is_full,
    output logic signed [bdeq_pkg::DATA_W-1:0]      o_front_value,
    output logic signed [bdeq_pkg::DATA_W-1:0]      o_rear_value,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic      [31:0]                        prdata,
    output logic                                    pready
);
    import bdeq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_MAX_I = (DEPTH > 31) ? 31 : DEPTH;
    localparam logic [CNT_W-1:0] LIM_MAX  = CNT_W'(LIM_MAX_I);
    localparam logic [AW:0]      DEPTH_S  = (AW+1)'(DEPTH);
    localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);

    // control state
    logic [AW-1:0]    r_head;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_capacity;
    logic             r_out_valid;

    // result payload
    logic             r_accepted;
    logic [CNT_W-1:0] r_res_count;
    logic             r_is_empty;
    logic             r_is_full;

    logic             in_xfer;
    logic [CNT_W-1:0] limit;
    logic             can_push;
    logic             can_pop;
    logic             ok;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    head_dec;
    logic [AW-1:0]    head_inc;
    logic [AW:0]      back_sum;
    logic [AW-1:0]    back_idx;
    logic [AW:0]      rear_sum;
    logic [AW-1:0]    rear_idx;
    logic [AW-1:0]    n_head;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] n_count_m1;
    logic             cfg_wr;
    logic [DATA_W-1:0] front_data;
    logic [DATA_W-1:0] rear_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign limit    = (r_capacity > LIM_MAX) ? LIM_MAX : r_capacity;
    assign can_push = r_count < limit;
    assign can_pop  = r_count != '0;

    // ring neighbors of the head
    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);

    // slot after the rear: head + count, count < DEPTH on a push
    assign back_sum = {1'b0, r_head} + (AW+1)'(r_count);
    assign back_idx = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);

    always_comb begin
        ok      = 1'b0;
        wr_en   = 1'b0;
        wr_addr = back_idx;
        n_head  = r_head;
        n_count = r_count;
        unique case (t_kind'(i_kind))
            KIND_PUSH_FRONT: begin
                if (can_push) begin
                    ok      = 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = head_dec;
                    n_head  = head_dec;
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_PUSH_BACK: begin
                if (can_push) begin
                    ok      = 1'b1;
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_POP_FRONT: begin
                if (can_pop) begin
                    ok      = 1'b1;
                    n_count = r_count - CNT_W'(1);
                    n_head  = (r_count == CNT_W'(1)) ? '0 : head_inc;
                end
            end
            KIND_POP_BACK: begin
                if (can_pop) begin
                    ok      = 1'b1;
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_head = '0;
                    end
                end
            end
            KIND_PEEK: begin
                ok = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // rear after the operation: head + count - 1 (only used when not empty)
    assign n_count_m1 = n_count - CNT_W'(1);
    assign rear_sum   = {1'b0, n_head} + (AW+1)'(n_count_m1);
    assign rear_idx   = (rear_sum >= DEPTH_S) ? AW'(rear_sum - DEPTH_S) : AW'(rear_sum);

    bdeq_ring #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk           (i_clk),
        .i_wr_en         (in_xfer && wr_en),
        .i_wr_addr       (wr_addr),
        .i_wr_data       (i_value),
        .i_rd_en         (in_xfer),
        .i_rd_front_addr (n_head),
        .i_rd_rear_addr  (rear_idx),
        .o_rd_front_data (front_data),
        .o_rd_rear_data  (rear_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_accepted  <= ok;
            r_res_count <= n_count;
            r_is_empty  <= (n_count == '0);
            r_is_full   <= (n_count >= limit);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_accepted;
    assign o_count       = r_res_count;
    assign o_is_empty    = r_is_empty;
    assign o_is_full     = r_is_full;
    assign o_front_value = r_is_empty ? EMPTY_VALUE : $signed(front_data);
    assign o_rear_value  = r_is_empty ? EMPTY_VALUE : $signed(rear_data);

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? {(32 - CNT_W)'(0), r_capacity} : 32'd0;

endmodule

`default_nettype wire

[design/bdeq_ring.sv]
`default_nettype none

// Ring storage: one write port, two registered read ports with write-first
// forwarding so a read sees the value written at the same edge.
module bdeq_ring #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_wr_en,
    input  wire logic [AW-1:0]                    i_wr_addr,
    input  wire logic [bdeq_pkg::DATA_W-1:0]      i_wr_data,
    input  wire logic                             i_rd_en,
    input  wire logic [AW-1:0]                    i_rd_front_addr,
    input  wire logic [AW-1:0]                    i_rd_rear_addr,
    output logic      [bdeq_pkg::DATA_W-1:0]      o_rd_front_data,
    output logic      [bdeq_pkg::DATA_W-1:0]      o_rd_rear_data
);
    import bdeq_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_front_data;
    logic [DATA_W-1:0] r_rear_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_front_addr)) begin
                r_front_data <= i_wr_data;
            end else begin
                r_front_data <= r_mem[i_rd_front_addr];
            end
            if (i_wr_en && (i_wr_addr == i_rd_rear_addr)) begin
                r_rear_data <= i_wr_data;
            end else begin
                r_rear_data <= r_mem[i_rd_rear_addr];
            end
        end
    end

    assign o_rd_front_data = r_front_data;
    assign o_rd_rear_data  = r_rear_data;

endmodule

`default_nettype wire
